### design/hrbc_pkg.sv
// Shared constants and control types of the history ring with browse cursor.
package hrbc_pkg;

  localparam int RING_DEPTH_DEF = 32;

  localparam int CMD_W  = 3;
  localparam int KEY_W  = 32;
  localparam int DATA_W = 64;

  // Request word: cmd, entry_key, entry_data, padded to whole bytes.
  localparam int IN_BITS = CMD_W + KEY_W + DATA_W;
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BACK    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FORWARD = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GET     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  typedef struct packed {
    logic capture;  // latch the accepted request
    logic execute;  // update pointers, write or read the ring
    logic load;     // move the finished result into the output register
  } hrbc_cmd_t;

  typedef struct packed {
    logic out_hold;  // output register full and not being taken this cycle
  } hrbc_stat_t;

endpackage

### design/history_ring_with_browse_cursor.sv
// Top level of the history ring with browse cursor: controller plus datapath.
//
// Requests arrive on the in_ stream. Each request carries a command (push, back,
// forward, get, clear), a 32-bit key and a 64-bit data word. Every request
// produces exactly one result on the out_ stream: an ok flag, the key and data
// of the entry under the cursor for back, forward and get, the can_back,
// can_forward and at_head flags and the fill count after the command.
// A request is taken in the capture step, executed in the execute step (pointer
// update, ring write for push, registered ring read at the new cursor slot) and
// then loaded into the output register in the load step, which raises out_tvalid.
// One request is in flight at a time: a new request is taken only after the
// one before it has been loaded into the output register.
// The output register keeps its result while out_tready is low, and the next
// request can be taken and executed meanwhile; it then waits before its load
// until the held result is taken. Reset empties the ring, puts the write
// pointer at slot zero and the cursor at the head; stored entries are not
// cleared and are read only after they were written.
module history_ring_with_browse_cursor
  import hrbc_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int CNT_W      = $clog2(RING_DEPTH + 1),
  parameter int OUT_W      = ((KEY_W + DATA_W + 4 + CNT_W + 7) / 8) * 8
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // [2:0] cmd, [34:3] entry_key, [98:35] entry_data, rest zero
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // [0] ok, [32:1] out_key, [96:33] out_data, [97] can_back, [98] can_forward,
  // [99] at_head, [99+CNT_W:100] fill_count, rest zero
  output logic [OUT_W-1:0] out_tdata
);

  localparam int PTR_W = $clog2(RING_DEPTH);

  hrbc_cmd_t  dp_cmd;
  hrbc_stat_t dp_stat;

  hrbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  hrbc_dp #(
    .RING_DEPTH (RING_DEPTH),
    .PTR_W      (PTR_W),
    .CNT_W      (CNT_W),
    .OUT_W      (OUT_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cmd        (dp_cmd),
    .stat       (dp_stat)
  );

endmodule

### design/hrbc_ctrl.sv
// Controller state machine: sequences capture, execution and result load.
module hrbc_ctrl
  import hrbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  hrbc_stat_t stat,
  output hrbc_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    cmd.load    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
        state_nxt   = ST_LOAD;
      end
      ST_LOAD: begin
        // Wait here only while the previous result is still held downstream.
        if (!stat.out_hold) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/hrbc_dp.sv
// Datapath: ring memories, write pointer, fill count, cursor and output register.
module hrbc_dp
  import hrbc_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int PTR_W      = $clog2(RING_DEPTH),
  parameter int CNT_W      = $clog2(RING_DEPTH + 1),
  parameter int OUT_W      = ((KEY_W + DATA_W + 4 + CNT_W + 7) / 8) * 8
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             out_tready,
  output logic             out_tvalid,
  output logic [OUT_W-1:0] out_tdata,
  input  hrbc_cmd_t        cmd,
  output hrbc_stat_t       stat
);

  localparam int OUT_BITS = 1 + KEY_W + DATA_W + 3 + CNT_W;
  localparam logic [PTR_W:0]   DEPTH_P = (PTR_W + 1)'(RING_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RING_DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(RING_DEPTH - 1);

  logic [KEY_W-1:0]  key_mem  [RING_DEPTH];
  logic [DATA_W-1:0] data_mem [RING_DEPTH];

  // Captured request (payload, no reset).
  logic [CMD_W-1:0]  cmd_r;
  logic [KEY_W-1:0]  key_in_r;
  logic [DATA_W-1:0] data_in_r;

  // Ring state. The cursor is held as browse offset plus one, so zero is at head.
  logic [PTR_W-1:0] wp_r,  wp_nxt;
  logic [CNT_W-1:0] vc_r,  vc_nxt;
  logic [PTR_W-1:0] pos_r, pos_nxt;
  logic [KEY_W-1:0] newest_key_r;

  logic              ok_r, ok_nxt;
  logic              hit_r, hit_nxt;
  logic              wr_en;
  logic [KEY_W-1:0]  rd_key_r;
  logic [DATA_W-1:0] rd_data_r;

  logic              dup;
  logic              back_ok;
  logic [PTR_W:0]    steps;
  logic [PTR_W:0]    diff;
  logic [PTR_W-1:0]  rd_addr;

  logic              can_back;
  logic [OUT_W-1:0]  res_word;
  logic [OUT_W-1:0]  out_data_r;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r     <= in_tdata[CMD_W-1:0];
      key_in_r  <= in_tdata[CMD_W +: KEY_W];
      data_in_r <= in_tdata[CMD_W+KEY_W +: DATA_W];
    end
  end

  assign dup     = (vc_r != '0) && (newest_key_r == key_in_r);
  assign back_ok = (vc_r != '0) &&
                   ((CNT_W + 1)'(pos_r) + (CNT_W + 1)'(2) <= (CNT_W + 1)'(vc_r));

  always_comb begin
    wp_nxt  = wp_r;
    vc_nxt  = vc_r;
    pos_nxt = pos_r;
    ok_nxt  = 1'b0;
    hit_nxt = 1'b0;
    wr_en   = 1'b0;
    case (cmd_r)
      CMD_PUSH: begin
        if (!dup) begin
          wr_en   = 1'b1;
          wp_nxt  = (wp_r == LAST_P) ? '0 : wp_r + PTR_W'(1);
          vc_nxt  = (vc_r < DEPTH_C) ? vc_r + CNT_W'(1) : vc_r;
          pos_nxt = '0;
          ok_nxt  = 1'b1;
        end
      end
      CMD_BACK: begin
        if (back_ok) begin
          pos_nxt = pos_r + PTR_W'(1);
          ok_nxt  = 1'b1;
          hit_nxt = 1'b1;
        end
      end
      CMD_FORWARD: begin
        if (pos_r != '0) begin
          pos_nxt = pos_r - PTR_W'(1);
          ok_nxt  = 1'b1;
          hit_nxt = 1'b1;
        end
      end
      CMD_GET: begin
        if (vc_r != '0) begin
          ok_nxt  = 1'b1;
          hit_nxt = 1'b1;
        end
      end
      CMD_CLEAR: begin
        wp_nxt  = '0;
        vc_nxt  = '0;
        pos_nxt = '0;
        ok_nxt  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // The head shows the newest entry; each step back from there adds one more slot.
  always_comb begin
    steps   = (pos_nxt == '0) ? (PTR_W + 1)'(1) : (PTR_W + 1)'(pos_nxt) + (PTR_W + 1)'(1);
    diff    = (PTR_W + 1)'(wp_r) + DEPTH_P - steps;
    rd_addr = (diff >= DEPTH_P) ? PTR_W'(diff - DEPTH_P) : diff[PTR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && wr_en) begin
      key_mem[wp_r]  <= key_in_r;
      data_mem[wp_r] <= data_in_r;
    end
    if (cmd.execute) begin
      rd_key_r  <= key_mem[rd_addr];
      rd_data_r <= data_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && wr_en) begin
      newest_key_r <= key_in_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      vc_r  <= '0;
      pos_r <= '0;
      ok_r  <= 1'b0;
      hit_r <= 1'b0;
    end else if (cmd.execute) begin
      wp_r  <= wp_nxt;
      vc_r  <= vc_nxt;
      pos_r <= pos_nxt;
      ok_r  <= ok_nxt;
      hit_r <= hit_nxt;
    end
  end

  // Status flags come from the state left by the command just executed.
  assign can_back = back_ok;

  always_comb begin
    res_word = '0;
    res_word[OUT_BITS-1:0] = {vc_r,
                              (pos_r == '0),
                              (pos_r != '0),
                              can_back,
                              hit_r ? rd_data_r : '0,
                              hit_r ? rd_key_r : '0,
                              ok_r};
  end

  assign out_valid_nxt = cmd.load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r <= res_word;
    end
  end

  assign stat.out_hold = out_valid_r && !out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;

endmodule

### test/history_ring_checker.sv
// Checker for the history ring: predicts each reply from the accepted requests and compares it.
module history_ring_checker
  import hrbc_pkg::*;
#(
  parameter int CNT_W = $clog2(RING_DEPTH_DEF + 1),
  parameter int OUT_W = ((KEY_W + DATA_W + 4 + CNT_W + 7) / 8) * 8
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  output int               fail_count,
  output int               outstanding
);

  localparam int PTR_W       = $clog2(RING_DEPTH_DEF);
  localparam int MAX_PRINTED = 200;

  typedef struct {
    logic              ok;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    logic              can_back;
    logic              can_forward;
    logic              at_head;
    logic [CNT_W-1:0]  fill;
  } reply_t;

  logic [KEY_W-1:0]  ring_key [RING_DEPTH_DEF];
  logic [DATA_W-1:0] ring_data [RING_DEPTH_DEF];
  logic [PTR_W-1:0]  head_ptr;
  int                fill_level;
  // Cursor offset: -1 shows the newest entry, p >= 0 the entry p+2 slots behind the head.
  int                cursor_ofs;
  reply_t            predicted_replies[$];

  function automatic logic [PTR_W-1:0] slot_behind(int steps);
    logic [PTR_W-1:0] span;
    span = steps[PTR_W-1:0];
    return head_ptr - span;
  endfunction

  function automatic logic older_reachable();
    return (fill_level > 0) && (cursor_ofs + 3 <= fill_level);
  endfunction

  function automatic reply_t predict_reply(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                           logic [DATA_W-1:0] data);
    reply_t           r;
    logic [PTR_W-1:0] slot;
    r.ok   = 1'b0;
    r.key  = '0;
    r.data = '0;
    case (cmd)
      CMD_PUSH: begin
        // A key equal to the newest entry's key leaves everything untouched.
        if (!(fill_level > 0 && ring_key[slot_behind(1)] == key)) begin
          ring_key[head_ptr]  = key;
          ring_data[head_ptr] = data;
          head_ptr++;
          if (fill_level < RING_DEPTH_DEF) fill_level++;
          cursor_ofs = -1;
          r.ok = 1'b1;
        end
      end
      CMD_BACK: begin
        if (older_reachable()) begin
          cursor_ofs++;
          r.ok = 1'b1;
        end
      end
      CMD_FORWARD: begin
        if (cursor_ofs >= 0) begin
          cursor_ofs--;
          r.ok = 1'b1;
        end
      end
      CMD_GET: r.ok = (fill_level > 0);
      CMD_CLEAR: begin
        head_ptr   = '0;
        fill_level = 0;
        cursor_ofs = -1;
        r.ok       = 1'b1;
      end
      default: ;
    endcase
    if (r.ok && (cmd == CMD_BACK || cmd == CMD_FORWARD || cmd == CMD_GET)) begin
      slot   = (cursor_ofs < 0) ? slot_behind(1) : slot_behind(cursor_ofs + 2);
      r.key  = ring_key[slot];
      r.data = ring_data[slot];
    end
    r.can_back    = older_reachable();
    r.can_forward = (cursor_ofs >= 0);
    r.at_head     = (cursor_ofs < 0);
    r.fill        = fill_level[CNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    if (fail_count < MAX_PRINTED)
      $display("mismatch at %0t: %s is %h, expected %h", $time, field, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    reply_t want;
    if (!rst_n) begin
      head_ptr   = '0;
      fill_level = 0;
      cursor_ofs = -1;
      fail_count = 0;
      predicted_replies.delete();
    end else begin
      // The reply taken at this edge always belongs to an earlier request.
      if (out_tvalid && out_tready) begin
        if (predicted_replies.size() == 0) begin
          report_mismatch("reply without a request", DATA_W'(1), DATA_W'(0));
        end else begin
          want = predicted_replies.pop_front();
          if (out_tdata[0] !== want.ok)
            report_mismatch("ok", DATA_W'(out_tdata[0]), DATA_W'(want.ok));
          if (out_tdata[32:1] !== want.key)
            report_mismatch("out_key", DATA_W'(out_tdata[32:1]), DATA_W'(want.key));
          if (out_tdata[96:33] !== want.data)
            report_mismatch("out_data", out_tdata[96:33], want.data);
          if (out_tdata[97] !== want.can_back)
            report_mismatch("can_back", DATA_W'(out_tdata[97]), DATA_W'(want.can_back));
          if (out_tdata[98] !== want.can_forward)
            report_mismatch("can_forward", DATA_W'(out_tdata[98]),
                            DATA_W'(want.can_forward));
          if (out_tdata[99] !== want.at_head)
            report_mismatch("at_head", DATA_W'(out_tdata[99]), DATA_W'(want.at_head));
          if (out_tdata[99+CNT_W:100] !== want.fill)
            report_mismatch("fill_count", DATA_W'(out_tdata[99+CNT_W:100]),
                            DATA_W'(want.fill));
        end
      end
      if (in_tvalid && in_tready)
        predicted_replies.push_back(predict_reply(in_tdata[2:0], in_tdata[34:3],
                                                  in_tdata[98:35]));
    end
    outstanding = predicted_replies.size();
  end

endmodule

### test/tb_history_ring_with_browse_cursor.sv
// Testbench top for the history ring: drives requests and receiver stalls, and gives the verdict.
module tb_history_ring_with_browse_cursor;
  import hrbc_pkg::*;

  localparam int CNT_W          = $clog2(RING_DEPTH_DEF + 1);
  localparam int OUT_W          = ((KEY_W + DATA_W + 4 + CNT_W + 7) / 8) * 8;
  localparam int REQUEST_TARGET = 1050;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int LONG_STALL     = 300;
  localparam int STALL_AFTER    = 300;

  // Codes the block does not define; it must ignore them.
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  typedef enum {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_TOGGLE} rx_mode_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             in_tready;
  logic             out_tready = 1'b0;
  logic             out_tvalid;
  logic [OUT_W-1:0] out_tdata;

  int               fail_count;
  int               outstanding;
  int               requests_sent   = 0;
  int               burst_left      = 0;
  logic [KEY_W-1:0] last_key        = '0;
  int unsigned      cycle_count     = 0;
  bit               long_stall_done = 1'b0;
  int               stall_left      = 0;
  rx_mode_t         rx_mode         = RX_ALWAYS;
  int               mode_left       = 0;

  always #4 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  history_ring_with_browse_cursor uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  history_ring_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Receiver: one long hold-off part way through, otherwise a ready pattern that changes mode.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!long_stall_done && requests_sent >= STALL_AFTER) begin
      long_stall_done <= 1'b1;
      stall_left      <= LONG_STALL;
      out_tready      <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(8, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_ALWAYS: out_tready <= 1'b1;
        RX_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
        RX_RARELY: out_tready <= ($urandom_range(0, 3) == 0);
        default:   out_tready <= ~out_tready;
      endcase
    end
  end

  // Offers one request and returns at the edge where it is taken. Requests go out in
  // bursts separated by random gaps.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                              input logic [DATA_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - IN_BITS){1'b0}}, data, key, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    requests_sent++;
    if (cmd == CMD_PUSH) last_key = key;
  endtask

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int               kind;
    int               n;
    int               m;
    logic [KEY_W-1:0] key;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty ring, duplicates, field extremes, refused steps, spare codes, clear.
    send_request(CMD_GET, '1, '1);
    send_request(CMD_BACK, '0, '0);
    send_request(CMD_FORWARD, '0, '0);
    send_request(CMD_PUSH, '0, '0);
    send_request(CMD_PUSH, '0, '1);
    send_request(CMD_PUSH, '1, '1);
    send_request(CMD_PUSH, 32'h0000_0001, 64'hA5A5_5A5A_0F0F_F0F0);
    send_request(CMD_BACK, '0, '0);
    send_request(CMD_BACK, '0, '0);
    send_request(CMD_BACK, '0, '0);
    send_request(CMD_GET, '0, '0);
    send_request(CMD_FORWARD, '0, '0);
    send_request(CMD_FORWARD, '0, '0);
    send_request(CMD_FORWARD, '0, '0);
    send_request(CMD_BACK, '0, '0);
    send_request(CMD_PUSH, 32'h0000_0001, '1);
    send_request(CMD_GET, '0, '0);
    send_request(CMD_PUSH, 32'h8000_0000, 64'h8000_0000_0000_0001);
    send_request(CMD_SPARE_FIRST, '1, '1);
    send_request(CMD_SPARE_MID, '0, '1);
    send_request(CMD_SPARE_LAST, '1, '0);
    send_request(CMD_CLEAR, '1, '1);
    send_request(CMD_GET, '0, '0);
    send_request(CMD_PUSH, 32'h8000_0000, '0);
    send_request(CMD_BACK, '0, '0);

    // Random part: mostly runs of pushes followed by walks back and forward, some noise.
    while (requests_sent < REQUEST_TARGET) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        n = $urandom_range(1, 40);
        repeat (n) begin
          key = ($urandom_range(0, 7) == 0) ? last_key : $urandom;
          send_request(CMD_PUSH, key, {$urandom, $urandom});
        end
      end else if (kind < 7) begin
        n = $urandom_range(1, 36);
        repeat (n)
          send_request(($urandom_range(0, 3) == 0) ? CMD_GET : CMD_BACK, $urandom,
                       {$urandom, $urandom});
        m = $urandom_range(0, n + 2);
        repeat (m)
          send_request(($urandom_range(0, 3) == 0) ? CMD_GET : CMD_FORWARD, $urandom,
                       {$urandom, $urandom});
      end else if (kind == 7) begin
        n = $urandom_range(1, 10);
        repeat (n)
          send_request(CMD_W'($urandom_range(CMD_PUSH, CMD_SPARE_LAST)), $urandom,
                       {$urandom, $urandom});
      end else if (kind == 8) begin
        send_request(($urandom_range(0, 3) == 0) ? CMD_CLEAR : CMD_GET, $urandom,
                     {$urandom, $urandom});
      end else begin
        n = $urandom_range(1, 8);
        repeat (n)
          send_request(($urandom_range(0, 1) == 0) ? CMD_BACK : CMD_FORWARD, $urandom,
                       {$urandom, $urandom});
      end
    end
    in_tvalid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
